>>> rtl/rfeu_pkg.sv
// Shared types, codes and widths for the register-format execute unit.
`timescale 1ns / 1ps

package rfeu_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REG_AW    = 5;
  localparam int unsigned REG_DEPTH = 1 << REG_AW;

  typedef enum logic [1:0] {
    ACT_EXEC  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_RESERVED  = 3'd1;
  localparam logic [2:0] STAT_UNKNOWN   = 3'd2;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd3;
  localparam logic [2:0] STAT_UNALIGNED = 3'd4;

  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_SRAV  = 6'h07;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  typedef struct packed {
    logic [2:0]        status;
    logic              jump_taken;
    logic [DATA_W-1:0] jump_target;
    logic              reg_written;
    logic [REG_AW-1:0] dest_index;
    logic [DATA_W-1:0] result_value;
    logic              hi_we;
    logic              lo_we;
    logic              mul_en;
    logic              mul_signed;
  } exec_res_t;

endpackage

>>> rtl/rfeu_regfile.sv
// General register file: synchronous memory with two read ports, valid bits and write forwarding.
`timescale 1ns / 1ps

module rfeu_regfile (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [rfeu_pkg::REG_AW-1:0] rd_addr_a,
  input  logic [rfeu_pkg::REG_AW-1:0] rd_addr_b,
  output logic [rfeu_pkg::DATA_W-1:0] rd_data_a,
  output logic [rfeu_pkg::DATA_W-1:0] rd_data_b,
  input  logic                       wr_en,
  input  logic [rfeu_pkg::REG_AW-1:0] wr_addr,
  input  logic [rfeu_pkg::DATA_W-1:0] wr_data
);

  logic [rfeu_pkg::DATA_W-1:0] mem [rfeu_pkg::REG_DEPTH];
  logic [rfeu_pkg::REG_DEPTH-1:0] vld_r;
  logic [rfeu_pkg::DATA_W-1:0] mem_a_r;
  logic [rfeu_pkg::DATA_W-1:0] mem_b_r;
  logic [rfeu_pkg::REG_AW-1:0] addr_a_r;
  logic [rfeu_pkg::REG_AW-1:0] addr_b_r;
  logic                        vld_a_r;
  logic                        vld_b_r;
  logic                        fwd_en_r;
  logic [rfeu_pkg::REG_AW-1:0] fwd_addr_r;
  logic [rfeu_pkg::DATA_W-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_a_r <= mem[rd_addr_a];
      mem_b_r <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_a_r <= rd_addr_a;
      addr_b_r <= rd_addr_b;
    end
    if (wr_en) begin
      fwd_addr_r <= wr_addr;
      fwd_data_r <= wr_data;
    end
  end

  // A write lands in the same edge as the read of the next beat, so the
  // latest write is kept and forwarded over the memory output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      vld_a_r  <= 1'b0;
      vld_b_r  <= 1'b0;
      fwd_en_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
        fwd_en_r       <= 1'b1;
      end
      if (rd_en) begin
        vld_a_r <= vld_r[rd_addr_a];
        vld_b_r <= vld_r[rd_addr_b];
      end
    end
  end

  always_comb begin
    if (fwd_en_r && (fwd_addr_r == addr_a_r)) begin
      rd_data_a = fwd_data_r;
    end else begin
      rd_data_a = vld_a_r ? mem_a_r : '0;
    end
    if (fwd_en_r && (fwd_addr_r == addr_b_r)) begin
      rd_data_b = fwd_data_r;
    end else begin
      rd_data_b = vld_b_r ? mem_b_r : '0;
    end
  end

endmodule

>>> rtl/rfeu_alu.sv
// Decode and execute logic for one beat: status, result value and state updates.
`timescale 1ns / 1ps

module rfeu_alu (
  input  logic [1:0]                  action,
  input  logic [rfeu_pkg::DATA_W-1:0] instruction_word,
  input  logic [rfeu_pkg::REG_AW-1:0] reg_index,
  input  logic [rfeu_pkg::DATA_W-1:0] write_value,
  input  logic [rfeu_pkg::DATA_W-1:0] vs,
  input  logic [rfeu_pkg::DATA_W-1:0] vt,
  input  logic [rfeu_pkg::DATA_W-1:0] hi_val,
  input  logic [rfeu_pkg::DATA_W-1:0] lo_val,
  output rfeu_pkg::exec_res_t         res
);

  logic [5:0]                  funct;
  logic [4:0]                  sh;
  logic [4:0]                  rd;
  logic [4:0]                  rt;
  logic [4:0]                  rs;
  logic                        known;
  logic                        resv;
  logic                        wr;
  logic [rfeu_pkg::DATA_W-1:0] val;
  logic [rfeu_pkg::DATA_W-1:0] sum;
  logic [rfeu_pkg::DATA_W-1:0] diff;
  logic                        add_ovf;
  logic                        sub_ovf;

  assign funct   = instruction_word[5:0];
  assign sh      = instruction_word[10:6];
  assign rd      = instruction_word[15:11];
  assign rt      = instruction_word[20:16];
  assign rs      = instruction_word[25:21];
  assign sum     = vs + vt;
  assign diff    = vs - vt;
  assign add_ovf = (~(vs[31] ^ vt[31])) & (vs[31] ^ sum[31]);
  assign sub_ovf = (vs[31] ^ vt[31]) & (vs[31] ^ diff[31]);

  always_comb begin
    known = 1'b1;
    resv  = 1'b0;
    wr    = 1'b0;
    val   = '0;
    case (funct)
      rfeu_pkg::FN_SLL: begin
        resv = rs != 5'd0; val = vt << sh; wr = 1'b1;
      end
      rfeu_pkg::FN_SRL: begin
        resv = rs != 5'd0; val = vt >> sh; wr = 1'b1;
      end
      rfeu_pkg::FN_SRA: begin
        resv = rs != 5'd0; val = $unsigned($signed(vt) >>> sh); wr = 1'b1;
      end
      rfeu_pkg::FN_SLLV: begin
        resv = sh != 5'd0; val = vt << vs[4:0]; wr = 1'b1;
      end
      rfeu_pkg::FN_SRLV: begin
        resv = sh != 5'd0; val = vt >> vs[4:0]; wr = 1'b1;
      end
      rfeu_pkg::FN_SRAV: begin
        resv = sh != 5'd0; val = $unsigned($signed(vt) >>> vs[4:0]); wr = 1'b1;
      end
      rfeu_pkg::FN_JR, rfeu_pkg::FN_MTHI, rfeu_pkg::FN_MTLO: begin
        resv = instruction_word[20:6] != 15'd0;
      end
      rfeu_pkg::FN_MFHI: begin
        resv = (rs != 5'd0) || (rt != 5'd0) || (sh != 5'd0); val = hi_val; wr = 1'b1;
      end
      rfeu_pkg::FN_MFLO: begin
        resv = (rs != 5'd0) || (rt != 5'd0) || (sh != 5'd0); val = lo_val; wr = 1'b1;
      end
      rfeu_pkg::FN_MULT, rfeu_pkg::FN_MULTU: begin
        resv = instruction_word[15:6] != 10'd0;
      end
      rfeu_pkg::FN_ADD, rfeu_pkg::FN_ADDU: begin
        resv = sh != 5'd0; val = sum; wr = 1'b1;
      end
      rfeu_pkg::FN_SUB, rfeu_pkg::FN_SUBU: begin
        resv = sh != 5'd0; val = diff; wr = 1'b1;
      end
      rfeu_pkg::FN_OR: begin
        resv = sh != 5'd0; val = vs | vt; wr = 1'b1;
      end
      rfeu_pkg::FN_XOR: begin
        resv = sh != 5'd0; val = vs ^ vt; wr = 1'b1;
      end
      rfeu_pkg::FN_SLT: begin
        resv = sh != 5'd0; val = {31'd0, $signed(vs) < $signed(vt)}; wr = 1'b1;
      end
      rfeu_pkg::FN_SLTU: begin
        resv = sh != 5'd0; val = {31'd0, vs < vt}; wr = 1'b1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  always_comb begin
    res = '0;
    case (rfeu_pkg::action_t'(action))
      rfeu_pkg::ACT_WRITE: begin
        res.dest_index   = reg_index;
        res.result_value = write_value;
        res.reg_written  = reg_index != '0;
      end
      rfeu_pkg::ACT_READ: begin
        res.dest_index   = reg_index;
        res.result_value = vs;
      end
      rfeu_pkg::ACT_EXEC: begin
        if (!known) begin
          res.status = rfeu_pkg::STAT_UNKNOWN;
        end else if (resv) begin
          res.status = rfeu_pkg::STAT_RESERVED;
        end else if (((funct == rfeu_pkg::FN_ADD) && add_ovf) ||
                     ((funct == rfeu_pkg::FN_SUB) && sub_ovf)) begin
          res.status = rfeu_pkg::STAT_OVERFLOW;
        end else if (funct == rfeu_pkg::FN_JR) begin
          if (vs[1:0] != 2'd0) begin
            res.status = rfeu_pkg::STAT_UNALIGNED;
          end else begin
            res.jump_taken  = 1'b1;
            res.jump_target = vs;
          end
        end else if (funct == rfeu_pkg::FN_MTHI) begin
          res.hi_we = 1'b1;
        end else if (funct == rfeu_pkg::FN_MTLO) begin
          res.lo_we = 1'b1;
        end else if ((funct == rfeu_pkg::FN_MULT) || (funct == rfeu_pkg::FN_MULTU)) begin
          res.mul_en     = 1'b1;
          res.mul_signed = funct == rfeu_pkg::FN_MULT;
        end else if (wr) begin
          res.dest_index   = rd;
          res.result_value = val;
          res.reg_written  = rd != 5'd0;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

>>> rtl/register_format_execute_unit.sv
// Top level of the register-format execute unit: pipeline control, HI/LO and multiplier.
//
// The unit takes one beat per cycle on the in_ channel (action, instruction word,
// register index, write value) and returns one beat per input on the out_ channel.
// A beat is accepted when its valid is high and its stall is low.
// Stage one issues the register reads to the register file memory; the memory
// returns data in the next cycle, where the beat is executed, the register file and
// HI/LO are updated, and the result is loaded into the output register.
// Throughput is one beat per cycle while the receiver does not stall, with any
// number of dependent beats back to back, made possible by the registered read
// of the register file and the write forwarding around it.
// MULT and MULTU register a 32 by 32 product; its sign correction is applied
// on the following cycle and forwarded to HI/LO readers.
// When the receiver stalls, the output register holds its beat, the execute
// stage holds one more, and in_stall rises once both are occupied.
// Synchronous reset clears the pipeline, HI, LO and all register valid bits,
// so every general register reads as zero until written. No clearing pass is
// needed, and the unit accepts beats as soon as reset is released.
`timescale 1ns / 1ps

module register_format_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_instruction_word,
  input  logic [4:0]  in_reg_index,
  input  logic [31:0] in_write_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_jump_taken,
  output logic [31:0] out_jump_target,
  output logic        out_reg_written,
  output logic [4:0]  out_dest_index,
  output logic [31:0] out_result_value
);

  logic                          in_accept;
  logic                          s1_go;
  logic                          s1_valid_r;
  logic [1:0]                    s1_action_r;
  logic [rfeu_pkg::DATA_W-1:0]   s1_iw_r;
  logic [rfeu_pkg::REG_AW-1:0]   s1_idx_r;
  logic [rfeu_pkg::DATA_W-1:0]   s1_wval_r;
  logic [rfeu_pkg::REG_AW-1:0]   rd_addr_a;
  logic [rfeu_pkg::DATA_W-1:0]   vs;
  logic [rfeu_pkg::DATA_W-1:0]   vt;
  rfeu_pkg::exec_res_t           res;
  rfeu_pkg::exec_res_t           out_r;
  logic                          out_valid_r;
  logic [rfeu_pkg::DATA_W-1:0]   hi_r;
  logic [rfeu_pkg::DATA_W-1:0]   lo_r;
  logic [rfeu_pkg::DATA_W-1:0]   hi_cur;
  logic [rfeu_pkg::DATA_W-1:0]   lo_cur;
  logic [rfeu_pkg::DATA_W-1:0]   hi_nxt;
  logic [rfeu_pkg::DATA_W-1:0]   lo_nxt;
  logic                          mul_pend_r;
  logic [2*rfeu_pkg::DATA_W-1:0] prod_r;
  logic [rfeu_pkg::DATA_W-1:0]   corr_r;
  logic [rfeu_pkg::DATA_W-1:0]   corr_nxt;

  assign s1_go     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_accept = in_valid && !in_stall;
  assign rd_addr_a = (in_action == rfeu_pkg::ACT_READ) ? in_reg_index
                                                         : in_instruction_word[25:21];

  rfeu_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_accept),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (in_instruction_word[20:16]),
    .rd_data_a (vs),
    .rd_data_b (vt),
    .wr_en     (s1_go && res.reg_written),
    .wr_addr   (res.dest_index),
    .wr_data   (res.result_value)
  );

  assign hi_cur = mul_pend_r ? (prod_r[2*rfeu_pkg::DATA_W-1:rfeu_pkg::DATA_W] - corr_r) : hi_r;
  assign lo_cur = mul_pend_r ? prod_r[rfeu_pkg::DATA_W-1:0] : lo_r;

  rfeu_alu u_alu (
    .action           (s1_action_r),
    .instruction_word (s1_iw_r),
    .reg_index        (s1_idx_r),
    .write_value      (s1_wval_r),
    .vs               (vs),
    .vt               (vt),
    .hi_val           (hi_cur),
    .lo_val           (lo_cur),
    .res              (res)
  );

  // The signed product differs from the unsigned one only in its upper half.
  assign corr_nxt = ((res.mul_signed && vs[31]) ? vt : '0) +
                    ((res.mul_signed && vt[31]) ? vs : '0);

  assign hi_nxt = (s1_go && res.hi_we) ? vs : hi_cur;
  assign lo_nxt = (s1_go && res.lo_we) ? vs : lo_cur;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action_r <= in_action;
      s1_iw_r     <= in_instruction_word;
      s1_idx_r    <= in_reg_index;
      s1_wval_r   <= in_write_value;
    end
    if (s1_go) begin
      out_r <= res;
    end
    if (s1_go && res.mul_en) begin
      prod_r <= {{rfeu_pkg::DATA_W{1'b0}}, vs} * {{rfeu_pkg::DATA_W{1'b0}}, vt};
      corr_r <= corr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hi_r        <= '0;
      lo_r        <= '0;
      mul_pend_r  <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      hi_r       <= hi_nxt;
      lo_r       <= lo_nxt;
      mul_pend_r <= s1_go && res.mul_en;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_jump_taken   = out_r.jump_taken;
  assign out_jump_target  = out_r.jump_target;
  assign out_reg_written  = out_r.reg_written;
  assign out_dest_index   = out_r.dest_index;
  assign out_result_value = out_r.result_value;

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("Input stalled without a held beat.");

  a_write_not_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reg_written) |-> ((out_dest_index != 5'd0) &&
      (out_status == rfeu_pkg::STAT_OK)))
    else $error("Register write reported with register zero or an error status.");

  a_jump_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_jump_taken) |-> ((out_jump_target[1:0] == 2'd0) &&
      !out_reg_written && (out_status == rfeu_pkg::STAT_OK)))
    else $error("Jump reported with an unaligned target or a write.");

  a_mul_pend_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_pend_r |-> $past(s1_go && res.mul_en))
    else $error("Product pending without a multiply in the previous cycle.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("Pipeline not empty after reset.");

endmodule

>>> test/execute_result_checker.sv
// Checker for the execute unit: tracks register, HI and LO state, predicts each result beat and compares.
`timescale 1ns / 1ps

module execute_result_checker
  import rfeu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [31:0]       in_instruction_word,
  input  logic [4:0]        in_reg_index,
  input  logic [31:0]       in_write_value,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [2:0]        out_status,
  input  logic              out_jump_taken,
  input  logic [31:0]       out_jump_target,
  input  logic              out_reg_written,
  input  logic [4:0]        out_dest_index,
  input  logic [31:0]       out_result_value,
  output int unsigned       mismatch_count,
  output int unsigned       results_pending,
  output int unsigned       results_checked
);

  typedef struct packed {
    logic [2:0]  status;
    logic        jump_taken;
    logic [31:0] jump_target;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [31:0] result_value;
  } result_beat_t;

  localparam logic [31:0] RSV_RT_RD_SA = 32'h001F_FFC0;
  localparam logic [31:0] RSV_RS_RT_SA = 32'h03FF_07C0;
  localparam logic [31:0] RSV_RD_SA    = 32'h0000_FFC0;
  localparam int unsigned REPORT_LIMIT = 10;

  logic [31:0]  gpr [REG_DEPTH];
  logic [31:0]  hi_reg;
  logic [31:0]  lo_reg;
  result_beat_t expected_results [$];

  function automatic result_beat_t execute_beat(logic [1:0] act, logic [31:0] iw,
                                                logic [4:0] idx, logic [31:0] wv);
    result_beat_t r;
    logic [5:0]   fn;
    logic [4:0]   sa, rd, rt, rs;
    logic [31:0]  vs, vt, val;
    logic [63:0]  prod;
    logic         known, rsv, wr;
    r     = '0;
    known = 1'b1;
    rsv   = 1'b0;
    wr    = 1'b0;
    val   = '0;
    prod  = '0;
    fn    = iw[5:0];
    sa    = iw[10:6];
    rd    = iw[15:11];
    rt    = iw[20:16];
    rs    = iw[25:21];
    vs    = gpr[rs];
    vt    = gpr[rt];
    case (act)
      ACT_WRITE: begin
        r.dest_index   = idx;
        r.result_value = wv;
        if (idx != '0) begin
          gpr[idx]      = wv;
          r.reg_written = 1'b1;
        end
      end
      ACT_READ: begin
        r.dest_index   = idx;
        r.result_value = gpr[idx];
      end
      ACT_EXEC: begin
        case (fn)
          FN_SLL: begin
            rsv = rs != '0; val = vt << sa; wr = 1'b1;
          end
          FN_SRL: begin
            rsv = rs != '0; val = vt >> sa; wr = 1'b1;
          end
          FN_SRA: begin
            rsv = rs != '0; val = $signed(vt) >>> sa; wr = 1'b1;
          end
          FN_SLLV: begin
            rsv = sa != '0; val = vt << vs[4:0]; wr = 1'b1;
          end
          FN_SRLV: begin
            rsv = sa != '0; val = vt >> vs[4:0]; wr = 1'b1;
          end
          FN_SRAV: begin
            rsv = sa != '0; val = $signed(vt) >>> vs[4:0]; wr = 1'b1;
          end
          FN_JR, FN_MTHI, FN_MTLO: rsv = (iw & RSV_RT_RD_SA) != '0;
          FN_MFHI: begin
            rsv = (iw & RSV_RS_RT_SA) != '0; val = hi_reg; wr = 1'b1;
          end
          FN_MFLO: begin
            rsv = (iw & RSV_RS_RT_SA) != '0; val = lo_reg; wr = 1'b1;
          end
          FN_MULT, FN_MULTU: rsv = (iw & RSV_RD_SA) != '0;
          FN_ADD, FN_ADDU: begin
            rsv = sa != '0; val = vs + vt; wr = 1'b1;
          end
          FN_SUB, FN_SUBU: begin
            rsv = sa != '0; val = vs - vt; wr = 1'b1;
          end
          FN_OR: begin
            rsv = sa != '0; val = vs | vt; wr = 1'b1;
          end
          FN_XOR: begin
            rsv = sa != '0; val = vs ^ vt; wr = 1'b1;
          end
          FN_SLT: begin
            rsv = sa != '0; val = {31'b0, $signed(vs) < $signed(vt)}; wr = 1'b1;
          end
          FN_SLTU: begin
            rsv = sa != '0; val = {31'b0, vs < vt}; wr = 1'b1;
          end
          default: known = 1'b0;
        endcase
        if (!known) begin
          r.status = STAT_UNKNOWN;
        end else if (rsv) begin
          r.status = STAT_RESERVED;
        end else if (fn == FN_ADD && vs[31] == vt[31] && val[31] != vs[31]) begin
          r.status = STAT_OVERFLOW;
        end else if (fn == FN_SUB && vs[31] != vt[31] && val[31] != vs[31]) begin
          r.status = STAT_OVERFLOW;
        end else if (fn == FN_JR) begin
          if (vs[1:0] != 2'b00) begin
            r.status = STAT_UNALIGNED;
          end else begin
            r.jump_taken  = 1'b1;
            r.jump_target = vs;
          end
        end else if (fn == FN_MTHI) begin
          hi_reg = vs;
        end else if (fn == FN_MTLO) begin
          lo_reg = vs;
        end else if (fn == FN_MULT || fn == FN_MULTU) begin
          if (fn == FN_MULT) begin
            prod = {{32{vs[31]}}, vs} * {{32{vt[31]}}, vt};
          end else begin
            prod = {32'b0, vs} * {32'b0, vt};
          end
          hi_reg = prod[63:32];
          lo_reg = prod[31:0];
        end else if (wr) begin
          r.dest_index   = rd;
          r.result_value = val;
          if (rd != '0) begin
            gpr[rd]       = val;
            r.reg_written = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : track_and_compare
    result_beat_t seen;
    result_beat_t want;
    if (!rst_n) begin
      for (int i = 0; i < REG_DEPTH; i++) gpr[i] = '0;
      hi_reg = '0;
      lo_reg = '0;
      expected_results.delete();
      mismatch_count  = 0;
      results_pending = 0;
      results_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = {out_status, out_jump_taken, out_jump_target, out_reg_written,
                out_dest_index, out_result_value};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] Result beat arrived with nothing expected: status=%0d value=%h",
                     $realtime, seen.status, seen.result_value);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("[%0t] Mismatch: expected status=%0d jump=%0b target=%h wr=%0b ",
                       $realtime, want.status, want.jump_taken, want.jump_target,
                       want.reg_written,
                       "dest=%0d value=%h, got status=%0d jump=%0b target=%h wr=%0b ",
                       want.dest_index, want.result_value, seen.status, seen.jump_taken,
                       seen.jump_target, seen.reg_written,
                       "dest=%0d value=%h", seen.dest_index, seen.result_value);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(execute_beat(in_action, in_instruction_word,
                                                in_reg_index, in_write_value));
      results_pending = expected_results.size();
    end
  end

endmodule

>>> test/register_format_execute_unit_tb.sv
// Testbench top for the execute unit: clock, reset, stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module register_format_execute_unit_tb;
  import rfeu_pkg::*;

  localparam int          HALF_PERIOD_NS = 6;
  localparam int          RESET_CYCLES   = 6;
  localparam int          RANDOM_BEATS   = 1870;
  localparam int          PRESSURE_BEATS = 100;
  localparam int          HOLD_CYCLES    = 64;
  localparam int          DRAIN_CYCLES   = 10;
  localparam int unsigned CYCLE_LIMIT    = 400000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [31:0] in_instruction_word;
  logic [4:0]  in_reg_index;
  logic [31:0] in_write_value;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic        out_jump_taken;
  logic [31:0] out_jump_target;
  logic        out_reg_written;
  logic [4:0]  out_dest_index;
  logic [31:0] out_result_value;

  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned results_checked;
  int unsigned cycle_count = 0;
  int          hold_requests = 0;
  int          exec_beats = 0;
  int          write_beats = 0;
  int          read_beats = 0;
  int          ignored_beats = 0;

  register_format_execute_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_instruction_word(in_instruction_word),
    .in_reg_index       (in_reg_index),
    .in_write_value     (in_write_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_jump_taken     (out_jump_taken),
    .out_jump_target    (out_jump_target),
    .out_reg_written    (out_reg_written),
    .out_dest_index     (out_dest_index),
    .out_result_value   (out_result_value)
  );

  execute_result_checker result_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_instruction_word(in_instruction_word),
    .in_reg_index       (in_reg_index),
    .in_write_value     (in_write_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_jump_taken     (out_jump_taken),
    .out_jump_target    (out_jump_target),
    .out_reg_written    (out_reg_written),
    .out_dest_index     (out_dest_index),
    .out_result_value   (out_result_value),
    .mismatch_count     (mismatch_count),
    .results_pending    (results_pending),
    .results_checked    (results_checked)
  );

  always #(HALF_PERIOD_NS) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, results_pending);
      $display("FAIL register_format_execute_unit");
      $finish;
    end
  end

  // Builds an instruction word; the opcode bits are ignored by the unit.
  function automatic logic [31:0] rword(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [4:0] sa, logic [5:0] fn);
    logic [5:0] opcode;
    opcode = 6'($urandom_range(0, 63));
    return {opcode, rs, rt, rd, sa, fn};
  endfunction

  // Most picks land on a few low registers so that beats depend on each other.
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 9) < 6) return 5'($urandom_range(0, 7));
    return 5'($urandom_range(0, 31));
  endfunction

  task automatic send_beat(input action_t act, input logic [31:0] iw, input logic [4:0] idx,
                           input logic [31:0] wv);
    in_valid            <= 1'b1;
    in_action           <= act;
    in_instruction_word <= iw;
    in_reg_index        <= idx;
    in_write_value      <= wv;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    case (act)
      ACT_EXEC:  exec_beats++;
      ACT_WRITE: write_beats++;
      ACT_READ:  read_beats++;
      default:   ignored_beats++;
    endcase
  endtask

  task automatic exec_op(input logic [4:0] rs, input logic [4:0] rt, input logic [4:0] rd,
                         input logic [4:0] sa, input logic [5:0] fn);
    send_beat(ACT_EXEC, rword(rs, rt, rd, sa, fn), 5'($urandom_range(0, 31)), $urandom);
  endtask

  task automatic write_reg(input logic [4:0] idx, input logic [31:0] val);
    send_beat(ACT_WRITE, $urandom, idx, val);
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic send_random_beat();
    int          k;
    int          bitpos;
    logic [4:0]  rs, rt, rd, sa;
    logic [5:0]  fn;
    logic [31:0] iw, val;
    k = $urandom_range(0, 99);
    if (k < 14) begin
      case ($urandom_range(0, 7))
        0:       val = '0;
        1:       val = 32'd1;
        2:       val = 32'h7FFF_FFFF;
        3:       val = 32'h8000_0000;
        4:       val = '1;
        5:       val = $urandom & ~32'h3;
        6:       val = $urandom_range(0, 40);
        default: val = $urandom;
      endcase
      write_reg(pick_reg(), val);
    end else if (k < 22) begin
      send_beat(ACT_READ, $urandom, pick_reg(), $urandom);
    end else if (k < 92) begin
      rs = pick_reg();
      rt = pick_reg();
      rd = pick_reg();
      sa = 5'($urandom_range(0, 31));
      case ($urandom_range(0, 20))
        0:       fn = FN_SLL;
        1:       fn = FN_SRL;
        2:       fn = FN_SRA;
        3:       fn = FN_SLLV;
        4:       fn = FN_SRLV;
        5:       fn = FN_SRAV;
        6:       fn = FN_JR;
        7:       fn = FN_MFHI;
        8:       fn = FN_MTHI;
        9:       fn = FN_MFLO;
        10:      fn = FN_MTLO;
        11:      fn = FN_MULT;
        12:      fn = FN_MULTU;
        13:      fn = FN_ADD;
        14:      fn = FN_ADDU;
        15:      fn = FN_SUB;
        16:      fn = FN_SUBU;
        17:      fn = FN_OR;
        18:      fn = FN_XOR;
        19:      fn = FN_SLT;
        default: fn = FN_SLTU;
      endcase
      case (fn)
        FN_SLL, FN_SRL, FN_SRA: rs = '0;
        FN_JR, FN_MTHI, FN_MTLO: begin
          rt = '0;
          rd = '0;
          sa = '0;
        end
        FN_MFHI, FN_MFLO: begin
          rs = '0;
          rt = '0;
          sa = '0;
        end
        FN_MULT, FN_MULTU: begin
          rd = '0;
          sa = '0;
        end
        default: sa = '0;
      endcase
      iw = rword(rs, rt, rd, sa, fn);
      if (k >= 88) begin
        bitpos     = $urandom_range(6, 25);
        iw[bitpos] = ~iw[bitpos];
      end
      send_beat(ACT_EXEC, iw, 5'($urandom_range(0, 31)), $urandom);
    end else if (k < 97) begin
      send_beat(ACT_EXEC, $urandom, 5'($urandom_range(0, 31)), $urandom);
    end else begin
      send_beat(ACT_NONE, $urandom, 5'($urandom_range(0, 31)), $urandom);
    end
  endtask

  initial begin : output_stalls
    int mode;
    int span_left;
    int holds_done;
    mode       = 0;
    span_left  = 0;
    holds_done = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_done < hold_requests) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (span_left == 0) begin
          mode      = $urandom_range(0, 3);
          span_left = $urandom_range(8, 60);
        end
        span_left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= $urandom_range(0, 99) < 30;
          2:       out_stall <= $urandom_range(0, 99) < 75;
          default: out_stall <= ~out_stall;
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int random_sent;
    int burst;
    random_sent = 0;
    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_action           <= ACT_EXEC;
    in_instruction_word <= '0;
    in_reg_index        <= '0;
    in_write_value      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(5'd1, 32'h7FFF_FFFF);
    write_reg(5'd2, 32'h8000_0000);
    write_reg(5'd31, 32'hFFFF_FFFF);
    write_reg(5'd0, 32'hDEAD_BEEF);
    send_beat(ACT_READ, '0, 5'd0, '0);
    send_beat(ACT_READ, '1, 5'd31, '1);
    exec_op(5'd1, 5'd1, 5'd4, 5'd0, FN_ADD);
    exec_op(5'd1, 5'd1, 5'd5, 5'd0, FN_ADDU);
    exec_op(5'd2, 5'd1, 5'd6, 5'd0, FN_SUB);
    exec_op(5'd2, 5'd1, 5'd6, 5'd0, FN_SUBU);
    exec_op(5'd2, 5'd1, 5'd7, 5'd0, FN_SLT);
    exec_op(5'd2, 5'd1, 5'd8, 5'd0, FN_SLTU);
    exec_op(5'd0, 5'd31, 5'd9, 5'd31, FN_SLL);
    exec_op(5'd0, 5'd2, 5'd10, 5'd31, FN_SRA);
    exec_op(5'd31, 5'd2, 5'd11, 5'd0, FN_SRAV);
    exec_op(5'd31, 5'd31, 5'd12, 5'd0, FN_SRLV);
    exec_op(5'd1, 5'd31, 5'd13, 5'd0, FN_SLLV);
    exec_op(5'd1, 5'd2, 5'd14, 5'd0, FN_OR);
    exec_op(5'd31, 5'd1, 5'd0, 5'd0, FN_XOR);
    exec_op(5'd2, 5'd31, 5'd0, 5'd0, FN_MULT);
    exec_op(5'd0, 5'd0, 5'd15, 5'd0, FN_MFHI);
    exec_op(5'd31, 5'd31, 5'd0, 5'd0, FN_MULTU);
    exec_op(5'd0, 5'd0, 5'd16, 5'd0, FN_MFLO);
    exec_op(5'd1, 5'd0, 5'd0, 5'd0, FN_MTHI);
    exec_op(5'd2, 5'd0, 5'd0, 5'd0, FN_MTLO);
    exec_op(5'd2, 5'd0, 5'd0, 5'd0, FN_JR);
    exec_op(5'd1, 5'd0, 5'd0, 5'd0, FN_JR);
    exec_op(5'd3, 5'd1, 5'd17, 5'd2, FN_SRL);
    exec_op(5'd1, 5'd0, 5'd5, 5'd0, FN_JR);
    exec_op(5'd0, 5'd0, 5'd0, 5'd0, 6'h3F);
    send_beat(ACT_NONE, '1, 5'd31, '1);
    idle_gap(3);

    hold_requests = 1;
    repeat (PRESSURE_BEATS) send_random_beat();
    random_sent = PRESSURE_BEATS;
    while (random_sent < RANDOM_BEATS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_random_beat();
        random_sent++;
        if (random_sent == RANDOM_BEATS / 2) hold_requests++;
      end
      idle_gap($urandom_range(0, 6));
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d instruction beats, %0d register writes, %0d reads and %0d ignored beats.",
             exec_beats, write_beats, read_beats, ignored_beats);
    $display("Compared %0d result beats across two long output hold-offs; %0d mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("PASS register_format_execute_unit");
    end else begin
      $display("FAIL register_format_execute_unit");
    end
    $finish;
  end

endmodule
